FILE: design/idks_pkg.sv
// ----------------------------------------------------------------------------
// idks_pkg
// Shared types and codes for the identifier-keyed slot table.
// ----------------------------------------------------------------------------
package idks_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam int KEY_W     = 31;
    localparam int PAYLOAD_W = 48;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PAYLOAD_W-1:0] found_payload;
    } rsp_t;

endpackage

FILE: design/idks_ram.sv
// ----------------------------------------------------------------------------
// idks_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module idks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/id_keyed_slot_table_core.sv
// ----------------------------------------------------------------------------
// id_keyed_slot_table_core
// Fixed-capacity table mapping nonzero identifiers to payload handles,
// searched linearly from slot 0.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the req channel (valid/ready) as a packed
// transaction carrying command, key and payload; each produces exactly one
// response transaction on the rsp channel (valid/ready) carrying status and
// found_payload. Insert reuses the lowest free slot below the high-water
// mark or appends at the mark; remove frees the lowest matching slot; find
// returns the payload of the lowest matching slot.
// Operation. A request is taken only in the idle state; the key memory is
// then scanned one slot per cycle through its single read port, up to the
// high-water mark; a match ends the scan early. A reserved key of zero or
// an unused command code skips the scan and goes straight to the response.
// One request is in progress at a time.
// Reset. rst_n clears the high-water mark, the state, data_ok and the
// response valid flag; the slot memories are not cleared, since only slots
// below the mark are ever read and every one of them has been written.
// Back-pressure. The response sits in an output register; while it waits
// for rsp_ready the next request is still accepted and scanned, and only its
// own response waits until the output register is free.
// ----------------------------------------------------------------------------
module id_keyed_slot_table_core
    import idks_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // Address width indexes the memories; count width can also hold CAPACITY.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Request held for the duration of the scan.
    logic [CMD_W-1:0]     cmd_reg;
    logic [KEY_W-1:0]     target_reg;      // key searched for (zero on insert)
    logic [KEY_W-1:0]     key_reg;
    logic [PAYLOAD_W-1:0] payload_reg;

    // Scan pointers: scan_idx is the address being read this cycle, chk_idx
    // the address whose data is on the memory outputs when data_ok is set.
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic [CW-1:0] chk_idx_reg, chk_idx_next;
    logic          data_ok_reg, data_ok_next;
    logic [CW-1:0] hw_reg, hw_next;

    // Result waiting for the output register.
    logic [STATUS_W-1:0]  pend_status_reg, pend_status_next;
    logic [PAYLOAD_W-1:0] pend_payload_reg, pend_payload_next;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;

    // Memory ports
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [KEY_W-1:0]     key_wdata;
    logic [PAYLOAD_W-1:0] pay_wdata;
    logic [KEY_W-1:0]     key_rdata;
    logic [PAYLOAD_W-1:0] pay_rdata;

    logic req_fire;
    logic out_free;
    logic hit;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign hit       = data_ok_reg && (key_rdata == target_reg);

    idks_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (key_wdata),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (key_rdata)
    );

    // The payload memory is read at the same address as the key memory, so
    // a find has its payload ready on the cycle the key matches.
    idks_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (CAPACITY)
    ) u_pay_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (pay_wdata),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (pay_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        scan_idx_next     = scan_idx_reg;
        chk_idx_next      = chk_idx_reg;
        data_ok_next      = 1'b0;
        hw_next           = hw_reg;
        pend_status_next  = pend_status_reg;
        pend_payload_next = pend_payload_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;
        mem_we            = 1'b0;
        mem_waddr         = chk_idx_reg[AW-1:0];
        key_wdata         = key_reg;
        pay_wdata         = payload_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    scan_idx_next     = '0;
                    pend_status_next  = STATUS_MISSING;
                    pend_payload_next = '0;
                    // Reserved key zero and the unused command code change
                    // nothing and answer not found straight away.
                    if ((req.key != '0) && (req.command inside {CMD_INSERT, CMD_REMOVE,
                                                                CMD_FIND}))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    // Lowest matching slot found at chk_idx.
                    state_next       = ST_RESP;
                    pend_status_next = STATUS_OK;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            mem_we = 1'b1;
                        end
                        CMD_REMOVE:
                        begin
                            mem_we    = 1'b1;
                            key_wdata = '0;
                            pay_wdata = '0;
                        end
                        default:
                        begin
                            pend_payload_next = pay_rdata;
                        end
                    endcase
                end
                else if (scan_idx_reg < hw_reg)
                begin
                    chk_idx_next  = scan_idx_reg;
                    data_ok_next  = 1'b1;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                else
                begin
                    // Every slot below the mark checked without a match.
                    state_next = ST_RESP;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        if (hw_reg != CW'(CAPACITY))
                        begin
                            mem_we           = 1'b1;
                            mem_waddr        = hw_reg[AW-1:0];
                            hw_next          = hw_reg + CW'(1);
                            pend_status_next = STATUS_OK;
                        end
                        else
                        begin
                            pend_status_next = STATUS_FULL;
                        end
                    end
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            data_ok_reg   <= 1'b0;
            hw_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            data_ok_reg   <= data_ok_next;
            hw_reg        <= hw_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg     <= req.command;
            key_reg     <= req.key;
            payload_reg <= req.payload;
            target_reg  <= (req.command == CMD_INSERT) ? '0 : req.key;
        end
        scan_idx_reg     <= scan_idx_next;
        chk_idx_reg      <= chk_idx_next;
        pend_status_reg  <= pend_status_next;
        pend_payload_reg <= pend_payload_next;
        if ((state_reg == ST_RESP) && out_free)
        begin
            rsp_reg.status        <= pend_status_reg;
            rsp_reg.found_payload <= pend_payload_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The high-water mark never exceeds the capacity.
    a_hw_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= CW'(CAPACITY))
        else $error("high-water mark beyond capacity");

    // The high-water mark never falls.
    a_hw_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> hw_reg >= $past(hw_reg))
        else $error("high-water mark decreased");

    // Only slots below the mark are ever compared.
    a_read_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
        data_ok_reg |-> chk_idx_reg < hw_reg)
        else $error("compared a slot at or above the high-water mark");

    // Memory writes happen only while scanning.
    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == ST_SCAN)
        else $error("memory write outside the scan");

    // A request with the reserved key goes straight to the response.
    a_zero_key_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.key == '0)) |=> state_reg == ST_RESP)
        else $error("reserved key started a scan");

endmodule

FILE: verif/tb_id_keyed_slot_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_id_keyed_slot_table_core
// Self-checking bench for the identifier-keyed slot table. Request
// transactions go through a short directed sequence and then through phases
// of random traffic that fill, churn, drain and refill the table. Both
// channels idle at random, and the response side is held off once for a long
// stretch. A tracker class keeps its own copy of the table and compares
// every response with the answer it predicts.
// ----------------------------------------------------------------------------
module tb_id_keyed_slot_table_core;
    import idks_pkg::*;

    localparam int CAPACITY = CAPACITY_DEFAULT;

    // Command code 3 has no meaning; the block must answer it as not found.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [KEY_W-1:0]     KEY_MAX     = '1;
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_MAX = '1;

    // Cycles without any accepted transaction before the run is abandoned.
    // The slowest legal stretch is the long response hold-off (HOLD_CYCLES)
    // plus a full scan, so this leaves a wide margin.
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------------
    // Tracker: holds a private copy of the table and the queue of answers
    // that are still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    class slot_table_tracker;
        logic [KEY_W-1:0]     slot_key [CAPACITY];
        logic [PAYLOAD_W-1:0] slot_payload [CAPACITY];
        int                   high_water;
        rsp_t                 owed_answers [$];
        int                   mismatches;

        function new();
            foreach (slot_key[i])
            begin
                slot_key[i]     = '0;
                slot_payload[i] = '0;
            end
            high_water = 0;
            mismatches = 0;
        endfunction

        // Lowest slot below the high-water mark that holds the key, or -1.
        function int lowest_slot_with(logic [KEY_W-1:0] k);
            for (int i = 0; i < high_water; i++)
            begin
                if (slot_key[i] == k)
                    return i;
            end
            return -1;
        endfunction

        // Applies an accepted request to the table copy and records the answer.
        function void note_request(req_t r);
            rsp_t answer;
            int   at;
            answer.status        = STATUS_MISSING;
            answer.found_payload = '0;
            if (r.key != '0)
            begin
                case (r.command)
                    CMD_INSERT:
                    begin
                        at = lowest_slot_with('0);
                        if (at < 0 && high_water < CAPACITY)
                        begin
                            at = high_water;
                            high_water++;
                        end
                        if (at >= 0)
                        begin
                            slot_key[at]     = r.key;
                            slot_payload[at] = r.payload;
                            answer.status    = STATUS_OK;
                        end
                        else
                            answer.status = STATUS_FULL;
                    end
                    CMD_REMOVE:
                    begin
                        at = lowest_slot_with(r.key);
                        if (at >= 0)
                        begin
                            slot_key[at]     = '0;
                            slot_payload[at] = '0;
                            answer.status    = STATUS_OK;
                        end
                    end
                    CMD_FIND:
                    begin
                        at = lowest_slot_with(r.key);
                        if (at >= 0)
                        begin
                            answer.found_payload = slot_payload[at];
                            answer.status        = STATUS_OK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            owed_answers.push_back(answer);
        endfunction

        function void check_answer(rsp_t got);
            rsp_t want;
            if (owed_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: response with none pending: status %0d payload %h",
                             got.status, got.found_payload);
                return;
            end
            want = owed_answers.pop_front();
            if (got.status !== want.status || got.found_payload !== want.found_payload)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: expected status %0d payload %h, got status %0d payload %h",
                             want.status, want.found_payload, got.status, got.found_payload);
            end
        endfunction

        function int outstanding();
            return owed_answers.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the signals of the block.
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    slot_table_tracker tracker = new();

    // Knobs shared by the sender and the receiver. The sender changes them
    // between phases; the receiver only reads them, apart from clearing the
    // hold request once it has taken it up.
    int gap_pct;
    int stall_pct;
    bit hold_request;
    int idle_cycles;

    // Keys that have been used in inserts, so that removes and finds hit.
    logic [KEY_W-1:0] known_keys [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    id_keyed_slot_table_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------------
    // Response side. Every accepted response transaction is checked at the
    // rising edge at which it is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            tracker.check_answer(rsp);
    end

    // The receiver changes rsp_ready only at falling edges, with at most one
    // assignment per edge. A hold request keeps it low for HOLD_CYCLES so the
    // output register stays full and the request side must stall behind it.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge clk);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any accepted transaction on either channel restarts the count.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_id_keyed_slot_table_core NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------------

    // Called at a falling edge. Presents the transaction, holds it until it is
    // accepted, notes it with the tracker and waits for the next falling edge.
    // The line may then idle for a random burst before the task returns.
    task automatic send_request(req_t r);
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        tracker.note_request(r);
        @(negedge clk);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    task automatic send_fields(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                               logic [PAYLOAD_W-1:0] p);
        req_t r;
        r.command = c;
        r.key     = k;
        r.payload = p;
        send_request(r);
    endtask

    // A fresh key with every bit random; the extremes turn up now and then.
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [31:0] bits;
        bits = $urandom();
        case ($urandom_range(0, 19))
            0:       return KEY_MAX;
            1:       return 31'd1;
            default: return (bits[KEY_W-1:0] == '0) ? 31'd1 : bits[KEY_W-1:0];
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] known_or_fresh_key(int known_pct);
        if (known_keys.size() > 0 && $urandom_range(0, 99) < known_pct)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        return fresh_key();
    endfunction

    // One random request. Most are well formed; noise_pct of them carry the
    // reserved key or the unused command code.
    function automatic req_t random_request(int ins_pct, int rem_pct, int noise_pct);
        req_t        r;
        logic [63:0] bits;
        int          roll;
        bits      = {$urandom(), $urandom()};
        r.payload = bits[PAYLOAD_W-1:0];
        roll      = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < noise_pct)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                r.command = CMD_UNUSED;
                r.key     = known_or_fresh_key(70);
            end
            else
            begin
                r.command = CMD_W'($urandom_range(0, 3));
                r.key     = '0;
            end
        end
        else if (roll < ins_pct)
        begin
            // Some inserts repeat a key already in use, so duplicates occur.
            r.command = CMD_INSERT;
            r.key     = known_or_fresh_key(25);
            known_keys.push_back(r.key);
            if (known_keys.size() > 160)
                void'(known_keys.pop_front());
        end
        else
        begin
            r.command = (roll < ins_pct + rem_pct) ? CMD_REMOVE : CMD_FIND;
            r.key     = known_or_fresh_key(80);
        end
        return r;
    endfunction

    task automatic run_phase(int count, int ins_pct, int rem_pct, int noise_pct);
        repeat (count)
            send_request(random_request(ins_pct, rem_pct, noise_pct));
    endtask

    task automatic wait_until_drained();
        while (tracker.outstanding() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_request = 1'b0;
        idle_cycles  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: an empty table, the reserved key, the unused code,
        // the extreme keys and payloads, reuse of a freed slot and duplicate
        // keys, where find and remove must act on the lowest matching slot.
        gap_pct   = 20;
        stall_pct = 20;
        send_fields(CMD_FIND,   KEY_MAX, PAYLOAD_MAX);
        send_fields(CMD_REMOVE, 31'd5,   '0);
        send_fields(CMD_INSERT, '0,      PAYLOAD_MAX);
        send_fields(CMD_UNUSED, 31'd5,   PAYLOAD_MAX);
        send_fields(CMD_INSERT, KEY_MAX, PAYLOAD_MAX);
        send_fields(CMD_INSERT, 31'd1,   '0);
        send_fields(CMD_INSERT, 31'd5,   48'h5555_5555_5555);
        send_fields(CMD_FIND,   KEY_MAX, '0);
        send_fields(CMD_FIND,   31'd1,   PAYLOAD_MAX);
        send_fields(CMD_FIND,   '0,      '0);
        send_fields(CMD_REMOVE, 31'd1,   PAYLOAD_MAX);
        send_fields(CMD_FIND,   31'd1,   '0);
        send_fields(CMD_INSERT, 31'd7,   48'hAAAA_AAAA_AAAA);
        send_fields(CMD_INSERT, 31'd5,   48'h1234_5678_9ABC);
        send_fields(CMD_FIND,   31'd5,   '0);
        send_fields(CMD_REMOVE, 31'd5,   '0);
        send_fields(CMD_FIND,   31'd5,   '0);
        send_fields(CMD_REMOVE, '0,      '0);
        send_fields(CMD_UNUSED, '0,      '0);
        send_fields(CMD_FIND,   31'd7,   '0);
        send_fields(CMD_REMOVE, KEY_MAX, '0);
        send_fields(CMD_REMOVE, KEY_MAX, '0);

        // Fill the table well past its capacity so out-of-space answers occur.
        gap_pct   = 30;
        stall_pct = 30;
        run_phase(150, 85, 5, 5);

        // Hold the response side off while requests keep coming, so the
        // output register stays occupied and the request channel stalls.
        hold_request = 1'b1;
        run_phase(40, 40, 30, 5);

        // Churn with heavy idling on both sides.
        gap_pct   = 60;
        stall_pct = 60;
        run_phase(200, 40, 35, 8);

        // Pause until every owed response has been taken.
        req_valid <= 1'b0;
        wait_until_drained();
        @(negedge clk);

        // Drain the table mostly by removes, then refill it with no idling
        // on the request side.
        gap_pct   = 15;
        stall_pct = 15;
        run_phase(150, 10, 60, 5);
        gap_pct   = 0;
        stall_pct = 40;
        run_phase(150, 60, 20, 5);

        // Last part: back-to-back traffic with no idling anywhere.
        gap_pct   = 0;
        stall_pct = 0;
        run_phase(120, 45, 25, 5);

        // Wait for the last responses, then for a full scan more so that any
        // stray response would still be caught.
        req_valid <= 1'b0;
        wait_until_drained();
        repeat (CAPACITY + 8) @(negedge clk);

        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("tb_id_keyed_slot_table_core OK");
        else
            $display("tb_id_keyed_slot_table_core NOT OK");
        $finish;
    end

endmodule
